// ----- design/scroll_gesture_classifier_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scroll gesture classifier
// Two concurrent assertion forms, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SCROLL_GESTURE_CLASSIFIER_ASSERT_SVH
`define SCROLL_GESTURE_CLASSIFIER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SGC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define SGC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SGC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define SGC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ----- design/sgc_pkg.sv -----
// ----------------------------------------------------------------------------
// sgc_pkg
// Types, thresholds and helper functions shared by the gesture classifier.
// ----------------------------------------------------------------------------
package sgc_pkg;

   typedef enum logic [1:0] {
      GESTURE_NONE  = 2'd0,
      GESTURE_WHEEL = 2'd1,
      GESTURE_PAN   = 2'd2,
      GESTURE_PINCH = 2'd3
   } gesture_type;

   typedef struct packed {
      logic               ctrl_held;
      logic               tick_y;
      logic               tick_x;
      logic signed [23:0] delta_y;
      logic signed [23:0] delta_x;
      logic        [63:0] time_ns;
      logic               is_scroll;
   } item_type;

   typedef struct packed {
      logic        wr;
      logic [31:0] data;
   } csr_wr_type;

   localparam int unsigned TDATA_IN_W  = 120;
   localparam int unsigned TDATA_OUT_W = 8;

   localparam logic [31:0] GAP_RESET   = 32'd150000000;
   localparam logic [22:0] MAG_MAX     = 23'h7FFFFF;
   localparam logic [22:0] ZERO_MAX    = 23'd65;
   localparam logic [22:0] SMALL_MAX   = 23'd36044;
   localparam logic [22:0] DETENT_LO   = 23'd58983;
   localparam logic [22:0] DETENT_HI   = 23'd229376;
   localparam logic [15:0] FRAC_TOL_LO = 16'd7864;
   localparam logic [15:0] FRAC_TOL_HI = 16'd57672;
   localparam logic [1:0]  COUNT_MAX   = 2'd3;

   // Q7.16 magnitude; the most negative code saturates.
   function automatic logic [22:0] magnitude(input logic [23:0] v);
      logic [23:0] neg;
      neg = 24'd0 - v;
      if (!v[23]) begin
         return v[22:0];
      end else if (v == 24'h800000) begin
         return MAG_MAX;
      end else begin
         return neg[22:0];
      end
   endfunction

   // Magnitude within range and within tolerance of a whole detent.
   function automatic logic is_detent(input logic [22:0] m);
      logic in_range;
      logic near;
      in_range = (m >= DETENT_LO) && (m <= DETENT_HI);
      near     = (m[15:0] <= FRAC_TOL_LO) || (m[15:0] >= FRAC_TOL_HI);
      return in_range && near;
   endfunction

endpackage

// ----- design/scroll_gesture_classifier.sv -----
// ----------------------------------------------------------------------------
// scroll_gesture_classifier
// Labels each event as none, mouse wheel, touchpad pan or pinch from burst
// history, tick flags and wheel-detent closeness of the scroll deltas.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Transfer when           Carries
// req_*     in         req_tvalid & tready     one event per transfer
// rsp_*     out        rsp_tvalid & tready     one gesture per event
// csr_*     in         csr_valid & csr_ready   burst_gap_ns (always ready)
//
// Each event is held in the input register and is classified on its way to
// the result register, one event per cycle sustained while the response side
// does not stall. The 64-bit gap subtract and compare against the burst
// state sets the path. The output register advances whenever it is empty or
// its content is taken, so a request is taken in the same cycle a stalled
// response drains. Synchronous reset empties both registers, clears the burst
// and loads the gap with its default.
// ----------------------------------------------------------------------------
module scroll_gesture_classifier
   import sgc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   // time_ns[63:0], delta_x[87:64], delta_y[111:88], tick_x[112],
   // tick_y[113], ctrl_held[114], zero[119:115]
   input  logic [TDATA_IN_W-1:0]  req_tdata,
   // is_scroll[0]
   input  logic                   req_tuser,

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // gesture[1:0], zero[7:2]
   output logic [TDATA_OUT_W-1:0] rsp_tdata,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [31:0]            csr_data
);

   item_type    in_item_ff, in_item_in;
   logic        in_valid_ff;
   logic        out_valid_ff;
   gesture_type gesture_ff;
   gesture_type gesture_calc;
   logic        advance;
   logic        req_fire;
   csr_wr_type  csr_wr;

   // The output slot frees when empty or when its transfer completes.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // The user must write configuration only while idle; the block does not enforce it and takes it at once.
   assign csr_ready   = 1'b1;
   assign csr_wr.wr   = csr_valid;
   assign csr_wr.data = csr_data;

   // Unpack the request fields; pad bits are dropped.
   always_comb begin
      in_item_in.is_scroll = req_tuser;
      in_item_in.time_ns   = req_tdata[63:0];
      in_item_in.delta_x   = req_tdata[87:64];
      in_item_in.delta_y   = req_tdata[111:88];
      in_item_in.tick_x    = req_tdata[112];
      in_item_in.tick_y    = req_tdata[113];
      in_item_in.ctrl_held = req_tdata[114];
   end

   // Input register: hold the event until the classifier commits it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
   end

   // Classify and update burst state as the event advances.
   sgc_classify_core u_core (
      .clock   (clock),
      .reset   (reset),
      .csr_wr  (csr_wr),
      .commit  (advance),
      .item    (in_item_ff),
      .gesture (gesture_calc)
   );

   // Result register: hold the verdict until the response transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         gesture_ff <= gesture_calc;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(TDATA_OUT_W - 2){1'b0}}, gesture_ff};

endmodule

// ----- design/sgc_classify_core.sv -----
// ----------------------------------------------------------------------------
// sgc_classify_core
// Burst state, gap register and single-pass verdict logic for one item.
// ----------------------------------------------------------------------------
module sgc_classify_core
   import sgc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  csr_wr_type  csr_wr,
   input  logic        commit,
   input  item_type    item,
   output gesture_type gesture
);

`include "scroll_gesture_classifier_assert.svh"

   logic [31:0] gap_ff;
   logic [63:0] last_time_ff, last_time_in;
   logic [1:0]  count_ff, count_in;
   logic [22:0] peak_x_ff, peak_x_in;
   logic [22:0] peak_y_ff, peak_y_in;
   logic        seen_x_ff, seen_x_in;
   logic        seen_y_ff, seen_y_in;
   gesture_type lock_ff, lock_in;

   logic [22:0] mx, my;
   logic        nz_x, nz_y;
   logic [63:0] elapsed;
   logic        expired;
   logic [1:0]  base_count;
   logic [22:0] base_px, base_py;
   logic        base_sx, base_sy;
   gesture_type base_lock;
   logic        multi, ticks, lock_now;
   gesture_type guess;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= GAP_RESET;
      end else if (csr_wr.wr) begin
         gap_ff <= csr_wr.data;
      end
   end

   always_comb begin
      mx      = magnitude(item.delta_x);
      my      = magnitude(item.delta_y);
      nz_x    = mx > ZERO_MAX;
      nz_y    = my > ZERO_MAX;
      elapsed = item.time_ns - last_time_ff;
      expired = (count_ff != 2'd0) && (elapsed > {32'd0, gap_ff});

      // Start from an empty burst when the idle gap ran out.
      base_count = expired ? 2'd0  : count_ff;
      base_px    = expired ? 23'd0 : peak_x_ff;
      base_py    = expired ? 23'd0 : peak_y_ff;
      base_sx    = expired ? 1'b0  : seen_x_ff;
      base_sy    = expired ? 1'b0  : seen_y_ff;
      base_lock  = expired ? GESTURE_NONE : lock_ff;

      last_time_in = last_time_ff;
      count_in     = count_ff;
      peak_x_in    = peak_x_ff;
      peak_y_in    = peak_y_ff;
      seen_x_in    = seen_x_ff;
      seen_y_in    = seen_y_ff;
      lock_in      = lock_ff;
      gesture      = GESTURE_NONE;
      multi        = 1'b0;
      ticks        = 1'b0;
      lock_now     = 1'b0;
      guess        = GESTURE_PAN;

      if (!item.is_scroll) begin
         gesture = GESTURE_NONE;
      end else if (item.ctrl_held && (nz_x || nz_y)) begin
         // Pinch: drop the whole burst.
         last_time_in = 64'd0;
         count_in     = 2'd0;
         peak_x_in    = 23'd0;
         peak_y_in    = 23'd0;
         seen_x_in    = 1'b0;
         seen_y_in    = 1'b0;
         lock_in      = GESTURE_NONE;
         gesture      = GESTURE_PINCH;
      end else if (!nz_x && !nz_y) begin
         gesture = GESTURE_NONE;
      end else begin
         last_time_in = item.time_ns;
         count_in     = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + 2'd1;
         peak_x_in    = (mx > base_px) ? mx : base_px;
         peak_y_in    = (my > base_py) ? my : base_py;
         seen_x_in    = base_sx | item.tick_x;
         seen_y_in    = base_sy | item.tick_y;
         lock_in      = base_lock;

         multi = count_in >= 2'd2;
         ticks = seen_x_in || seen_y_in;
         if (ticks) begin
            guess = GESTURE_WHEEL;
         end else if (nz_x) begin
            guess = (!multi && is_detent(mx)) ? GESTURE_WHEEL : GESTURE_PAN;
         end else begin
            guess = (!multi && is_detent(my)) ? GESTURE_WHEEL : GESTURE_PAN;
         end
         lock_now = ticks || multi || ((guess == GESTURE_WHEEL) &&
                    (is_detent(peak_y_in) || is_detent(peak_x_in)));

         if (base_lock != GESTURE_NONE) begin
            gesture = base_lock;
         end else begin
            gesture = guess;
            if (lock_now) begin
               lock_in = guess;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= 64'd0;
         count_ff     <= 2'd0;
         peak_x_ff    <= 23'd0;
         peak_y_ff    <= 23'd0;
         seen_x_ff    <= 1'b0;
         seen_y_ff    <= 1'b0;
         lock_ff      <= GESTURE_NONE;
      end else if (commit) begin
         last_time_ff <= last_time_in;
         count_ff     <= count_in;
         peak_x_ff    <= peak_x_in;
         peak_y_ff    <= peak_y_in;
         seen_x_ff    <= seen_x_in;
         seen_y_ff    <= seen_y_in;
         lock_ff      <= lock_in;
      end
   end

   `SGC_ASSERT_IMPLY(a_lock_needs_burst, clock, reset, lock_ff != GESTURE_NONE, count_ff != 2'd0)
   `SGC_ASSERT_IMPLY(a_empty_burst_clean, clock, reset, count_ff == 2'd0,
      peak_x_ff == 23'd0 && peak_y_ff == 23'd0 && !seen_x_ff && !seen_y_ff)
   `SGC_ASSERT_NEXT(a_pinch_clears, clock, reset, commit && gesture == GESTURE_PINCH,
      count_ff == 2'd0 && lock_ff == GESTURE_NONE)
   `SGC_ASSERT_IMPLY(a_locked_holds, clock, reset,
      commit && item.is_scroll && !item.ctrl_held && !expired && lock_ff != GESTURE_NONE
      && (nz_x || nz_y), gesture == lock_ff)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scroll gesture classifier testbench
// Drives scroll events through the request stream and checks each gesture on
// the response stream against an in-bench burst tracker. It starts with a
// directed set of threshold and burst corner cases. Then come random burst
// sequences, run under several burst gap settings, with random stalls on
// both streams.
// ----------------------------------------------------------------------------
module tb;
   import sgc_pkg::*;

   // Q7.16 thresholds on raw magnitudes
   localparam logic [22:0] NEAR_ZERO    = 23'd65;
   localparam logic [22:0] SMALL_LIMIT  = 23'd36044;
   localparam logic [22:0] DETENT_MIN   = 23'd58983;
   localparam logic [22:0] DETENT_MAX   = 23'd229376;
   localparam logic [16:0] DETENT_SLACK = 17'd7864;
   localparam logic [22:0] MAG_SAT      = 23'h7FFFFF;
   localparam logic [31:0] GAP_DEFAULT  = 32'd150000000;
   localparam int          LONG_HOLD_AT = 250;
   localparam int          LONG_HOLD    = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // time_ns[63:0], delta_x[87:64], delta_y[111:88], tick_x[112],
   // tick_y[113], ctrl_held[114], zero[119:115]
   logic [TDATA_IN_W-1:0]  req_tdata = '0;
   // is_scroll[0]
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // gesture[1:0], zero[7:2]
   logic [TDATA_OUT_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [31:0]            csr_data = '0;

   scroll_gesture_classifier u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Events waiting to be sent, and gestures still owed by the block
   item_type    pending_events[$];
   gesture_type owed_gestures[$];
   int          mismatches = 0;

   // Burst tracker state, mirrored from the block
   logic [31:0] gap_ns       = GAP_DEFAULT;
   logic [63:0] last_ns      = '0;
   logic [1:0]  burst_len    = '0;
   logic [22:0] peak_x       = '0;
   logic [22:0] peak_y       = '0;
   logic        saw_tick_x   = 1'b0;
   logic        saw_tick_y   = 1'b0;
   gesture_type held_verdict = GESTURE_NONE;

   // Timestamp of the most recently queued event
   logic [63:0] now_ns = 64'd1000;

   task automatic note_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
   endtask

   function automatic logic [22:0] delta_mag(input logic [23:0] d);
      logic [23:0] n;
      n = 24'd0 - d;
      if (!d[23]) return d[22:0];
      // most negative code has no positive twin: saturate
      if (d[22:0] == 23'd0) return MAG_SAT;
      return n[22:0];
   endfunction

   function automatic logic near_detent(input logic [22:0] m);
      logic [16:0] frac_off;
      if (m < DETENT_MIN || m > DETENT_MAX) return 1'b0;
      frac_off = (m[15:0] <= 16'h8000) ? {1'b0, m[15:0]} : 17'h10000 - {1'b0, m[15:0]};
      return frac_off <= DETENT_SLACK;
   endfunction

   function automatic void clear_burst_state();
      last_ns      = '0;
      burst_len    = '0;
      peak_x       = '0;
      peak_y       = '0;
      saw_tick_x   = 1'b0;
      saw_tick_y   = 1'b0;
      held_verdict = GESTURE_NONE;
   endfunction

   // Advance the burst tracker by one event and return its gesture
   function automatic gesture_type classify_event(input item_type ev);
      logic [22:0] mx;
      logic [22:0] my;
      logic        multi;
      logic        ticked;
      gesture_type guess;
      mx = delta_mag(ev.delta_x);
      my = delta_mag(ev.delta_y);
      if (!ev.is_scroll) return GESTURE_NONE;
      if (ev.ctrl_held && (mx > NEAR_ZERO || my > NEAR_ZERO)) begin
         clear_burst_state();
         return GESTURE_PINCH;
      end
      if (mx <= NEAR_ZERO && my <= NEAR_ZERO) return GESTURE_NONE;

      // idle too long: start a fresh burst before counting this event
      if (burst_len != 2'd0 && (ev.time_ns - last_ns) > {32'd0, gap_ns})
         clear_burst_state();
      last_ns = ev.time_ns;
      if (burst_len != 2'd3) burst_len++;
      if (my > peak_y) peak_y = my;
      if (mx > peak_x) peak_x = mx;
      if (ev.tick_y) saw_tick_y = 1'b1;
      if (ev.tick_x) saw_tick_x = 1'b1;

      if (held_verdict != GESTURE_NONE) return held_verdict;

      multi  = burst_len >= 2'd2;
      ticked = saw_tick_x || saw_tick_y;
      guess  = GESTURE_PAN;
      if (ticked) begin
         guess = GESTURE_WHEEL;
      end else if (mx > NEAR_ZERO) begin
         if (!multi && near_detent(mx)) guess = GESTURE_WHEEL;
      end else if (!multi && near_detent(my)) begin
         guess = GESTURE_WHEEL;
      end else if (!multi && my <= SMALL_LIMIT) begin
         guess = GESTURE_PAN;
      end

      if (ticked || multi ||
          (guess == GESTURE_WHEEL && (near_detent(peak_y) || near_detent(peak_x))))
         held_verdict = guess;
      return guess;
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: present one event per transfer, draw an idle count
   // after each. Every 48 events, randomly switch to a calm stretch with no
   // idling so back-to-back traffic is covered too.
   // ------------------------------------------------------------------------
   item_type sent_event;
   int       send_wait  = 0;
   int       send_total = 0;
   logic     send_calm  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            // transfer taken: predict now so the gesture queue stays in order
            owed_gestures.push_back(classify_event(sent_event));
            send_total++;
            if (send_total % 48 == 0) send_calm = ($urandom_range(0, 2) == 0);
            send_wait = send_calm ? 0 : $urandom_range(0, 14);
         end
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_events.size() != 0) begin
               sent_event = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= sent_event.is_scroll;
               req_tdata  <= {5'd0, sent_event.ctrl_held, sent_event.tick_y,
                              sent_event.tick_x, sent_event.delta_y,
                              sent_event.delta_x, sent_event.time_ns};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: check each transfer against the oldest owed gesture,
   // then stall for a random count. Once, hold off long enough for the block
   // to fill and back-pressure the request side.
   // ------------------------------------------------------------------------
   gesture_type want;
   int          recv_wait  = 0;
   int          recv_total = 0;
   logic        recv_calm  = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_gestures.size() == 0) begin
               note_mismatch($sformatf("gesture %0d with none owed", rsp_tdata[1:0]));
            end else begin
               want = owed_gestures.pop_front();
               if (rsp_tdata[1:0] !== want)
                  note_mismatch($sformatf("gesture got %0d want %s",
                                          rsp_tdata[1:0], want.name()));
            end
            recv_total++;
            if (recv_total == LONG_HOLD_AT) begin
               recv_wait = LONG_HOLD;
            end else begin
               if (recv_total % 40 == 0) recv_calm = ($urandom_range(0, 2) == 0);
               recv_wait = recv_calm ? 0 : $urandom_range(0, 14);
            end
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_event(input logic scroll, input logic [63:0] dt,
                              input logic [23:0] dx, input logic [23:0] dy,
                              input logic tx, input logic ty, input logic ctrl);
      item_type ev;
      now_ns       = now_ns + dt;
      ev.is_scroll = scroll;
      ev.time_ns   = now_ns;
      ev.delta_x   = dx;
      ev.delta_y   = dy;
      ev.tick_x    = tx;
      ev.tick_y    = ty;
      ev.ctrl_held = ctrl;
      pending_events.push_back(ev);
   endtask

   // Hold until the block has drained, then let the pipeline settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || owed_gestures.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_gap(input logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      gap_ns = value;
   endtask

   function automatic logic [23:0] signed_mag(input logic [22:0] m);
      logic [23:0] v;
      v = {1'b0, m};
      if ($urandom_range(0, 1)) v = 24'd0 - v;
      return v;
   endfunction

   // Near-zero delta that the block treats as no motion
   function automatic logic [23:0] rand_still();
      return signed_mag(23'($urandom_range(0, 65)));
   endfunction

   function automatic logic [23:0] rand_delta();
      int k;
      case ($urandom_range(0, 7))
         0: return rand_still();
         1: return signed_mag(23'($urandom_range(66, 36044)));
         2: begin
            // around a whole detent, straddling the tolerance
            k = $urandom_range(1, 3) * 65536 + $urandom_range(0, 18000) - 9000;
            return signed_mag(23'(k));
         end
         3: return 24'($urandom);
         4: begin
            case ($urandom_range(0, 8))
               0: return 24'h800000;
               1: return signed_mag(MAG_SAT);
               2: return signed_mag(DETENT_MIN);
               3: return signed_mag(DETENT_MIN - 23'd1);
               4: return signed_mag(DETENT_MAX);
               5: return signed_mag(DETENT_MAX + 23'd1);
               6: return signed_mag(NEAR_ZERO);
               7: return signed_mag(NEAR_ZERO + 23'd1);
               default: return signed_mag(SMALL_LIMIT);
            endcase
         end
         default: return signed_mag(23'($urandom_range(36045, 300000)));
      endcase
   endfunction

   // Time step that usually opens a new burst
   function automatic logic [63:0] rand_break_dt();
      case ($urandom_range(0, 4))
         0: return {32'd0, gap_ns} + 64'd1;
         1: return {32'd0, gap_ns} + 64'd1 + 64'($urandom_range(0, 1000000));
         2: return {$urandom, $urandom};
         3: return {32'd0, gap_ns};
         default: return 64'($urandom_range(0, gap_ns));
      endcase
   endfunction

   // Time step that keeps the burst alive
   function automatic logic [63:0] rand_burst_dt();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return {32'd0, gap_ns};
         default: return 64'($urandom_range(0, gap_ns));
      endcase
   endfunction

   // Mostly well-formed bursts with random content; the rest is noise:
   // non-scroll events, still deltas and pinches. Only burst events and pinches count.
   task automatic run_random(input int count);
      int          done;
      int          len;
      logic [23:0] dx;
      logic [23:0] dy;
      done = 0;
      while (done < count) begin
         case ($urandom_range(0, 9))
            7: queue_event(1'b0, 64'($urandom_range(0, 1000)), 24'($urandom),
                           24'($urandom), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            8: queue_event(1'b1, rand_burst_dt(), rand_still(), rand_still(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
            9: begin
               queue_event(1'b1, rand_burst_dt(), rand_delta(), rand_delta(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1);
               done++;
            end
            default: begin
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++) begin
                  dx = rand_delta();
                  dy = rand_delta();
                  case ($urandom_range(0, 3))
                     0: dx = rand_still();
                     1: dy = rand_still();
                     2: dx = 24'd0;
                     default: ;
                  endcase
                  queue_event(1'b1, (i == 0) ? rand_break_dt() : rand_burst_dt(),
                              dx, dy, $urandom_range(0, 5) == 0,
                              $urandom_range(0, 5) == 0, $urandom_range(0, 15) == 0);
                  done++;
               end
            end
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [63:0] gap;
      gap = {32'd0, GAP_DEFAULT};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners at the reset gap
      queue_event(1'b0, 64'd10, 24'h7FFFFF, 24'hFFFFFF, 1'b1, 1'b1, 1'b1);
      queue_event(1'b1, 64'd10, 24'd0, 24'd65, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, 64'd10, 24'd66, 24'd0, 1'b0, 1'b0, 1'b1);
      queue_event(1'b1, 64'd10, -24'd65, 24'd0, 1'b0, 1'b0, 1'b1);
      // single detent locks wheel for the burst
      queue_event(1'b1, 64'd10, 24'd0, 24'd65536, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, 64'd100, 24'd0, 24'd1000, 1'b0, 1'b0, 1'b0);
      // most negative delta after the gap runs out; then exact-gap steps
      queue_event(1'b1, gap + 64'd1, 24'h800000, 24'd0, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap, 24'd0, 24'h7FFFFF, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap, 24'd100, 24'd0, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, 64'd5, 24'd100, 24'd0, 1'b0, 1'b0, 1'b0);
      // detent range and tolerance edges, each in a fresh burst
      queue_event(1'b1, gap + 64'd1, 24'd0, 24'd58983, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap + 64'd1, 24'd0, -24'd229376, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap + 64'd1, 24'd0, 24'd58982, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap + 64'd1, 24'd0, 24'd229377, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap + 64'd1, 24'd73400, 24'd0, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap + 64'd1, -24'd73401, 24'd0, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap + 64'd1, 24'd0, 24'd123208, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap + 64'd1, 24'd0, 24'd36044, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, gap + 64'd1, 24'd30000, 24'd65536, 1'b0, 1'b0, 1'b0);
      // tick flags force the wheel verdict
      queue_event(1'b1, gap + 64'd1, 24'd0, 24'd3000, 1'b0, 1'b1, 1'b0);
      queue_event(1'b1, gap + 64'd1, 24'd5000, 24'd0, 1'b1, 1'b0, 1'b0);
      // pinch in the middle of a locked burst
      queue_event(1'b1, 64'd7, 24'd0, -24'd400, 1'b0, 1'b0, 1'b1);
      // zero timestamp, then a wrap of the 64-bit time
      now_ns = 64'd0;
      queue_event(1'b1, 64'd0, 24'd200, 24'd200, 1'b0, 1'b0, 1'b0);
      now_ns = 64'hFFFF_FFFF_FFFF_FFF0;
      queue_event(1'b1, 64'd0, 24'd0, 24'd65536, 1'b0, 1'b0, 1'b0);
      queue_event(1'b1, 64'h20, 24'd0, 24'd900, 1'b0, 1'b0, 1'b0);
      wait_drained();

      write_gap(32'd0);
      run_random(150);
      wait_drained();

      write_gap(32'hFFFF_FFFF);
      run_random(160);
      wait_drained();

      write_gap(32'($urandom_range(1000, 5000000)));
      run_random(160);
      wait_drained();

      write_gap($urandom);
      run_random(160);
      wait_drained();

      write_gap(GAP_DEFAULT);
      run_random(170);

      do @(negedge clock);
      while (pending_events.size() != 0 || req_tvalid || owed_gestures.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run
   initial begin
      #1000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
